// File: rtl/lzb_pkg.sv
// ----------------------------------------------------------------------------
// lzb_pkg
// Shared types and constants for the byte-token LZ decompressor.
// ----------------------------------------------------------------------------
package lzb_pkg;

  localparam int unsigned MAX_OUTPUT_DEF   = 32'hC000;
  localparam int unsigned WINDOW_DEPTH_DEF = 8192;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned DH_W       = 12;
  localparam int unsigned DIST_W     = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL  = 1'b1;

  // fill length is token minus 61
  localparam logic [LEN_W-1:0] FILL_BIAS = 7'd61;
  localparam logic [LEN_W-1:0] REF_BIAS0 = 7'd3;
  localparam logic [LEN_W-1:0] REF_BIAS1 = 7'd5;

  typedef enum logic [1:0] {
    PH_TOKEN = 2'd0,
    PH_DIST  = 2'd1,
    PH_FILL  = 2'd2,
    PH_LIT   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    FS_ONGOING = 2'd0,
    FS_OK      = 2'd1,
    FS_ERR     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_RUN   = 2'd1,
    S_FINAL = 2'd2
  } fsm_t;

  // one byte event from the sequencer to the write-back/packing stage
  typedef struct packed {
    logic    has_byte;
    logic    from_mem;
    logic    write;
    logic    last;
    status_t status;
  } iss_t;

endpackage

// File: rtl/lzb_in_if.sv
// ----------------------------------------------------------------------------
// lzb_in_if
// Compressed byte channel: valid/ready with one packed byte per request.
// ----------------------------------------------------------------------------
interface lzb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       stream_end;

  modport source (output valid, output packed_byte, output stream_end, input ready);
  modport sink (input valid, input packed_byte, input stream_end, output ready);
endinterface

// File: rtl/lzb_out_if.sv
// ----------------------------------------------------------------------------
// lzb_out_if
// Decoded byte channel: valid/ready with up to two bytes per request.
// ----------------------------------------------------------------------------
interface lzb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [1:0] byte_count;
  logic       run_last;
  logic [1:0] frame_status;

  modport source (
    output valid, output first_byte, output second_byte, output byte_count,
    output run_last, output frame_status, input ready
  );
  modport sink (
    input valid, input first_byte, input second_byte, input byte_count,
    input run_last, input frame_status, output ready
  );
endinterface

// File: rtl/lzb_hist_ram.sv
// ----------------------------------------------------------------------------
// lzb_hist_ram
// History window: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lzb_hist_ram #(
  parameter int unsigned DEPTH = lzb_pkg::WINDOW_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/lzb_seq.sv
// ----------------------------------------------------------------------------
// lzb_seq
// Token decoder and byte sequencer: holds frame state, issues history reads
// for back-references and one byte event per cycle to the packing stage while it is ready.
// ----------------------------------------------------------------------------
module lzb_seq #(
  parameter int unsigned MAX_OUTPUT   = lzb_pkg::MAX_OUTPUT_DEF,
  parameter int unsigned WINDOW_DEPTH = lzb_pkg::WINDOW_DEPTH_DEF,
  localparam int unsigned AW = $clog2(WINDOW_DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst,
  lzb_in_if.sink                              in_ch,
  input  logic                                cfg_we,
  input  logic [lzb_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [lzb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output lzb_pkg::iss_t                       iss,
  output logic                                iss_valid,
  input  logic                                iss_ready,
  output logic [7:0]                          iss_byte,
  output logic [AW-1:0]                       iss_waddr,
  output logic                                rd_en,
  output logic [AW-1:0]                       rd_addr
);

  import lzb_pkg::*;

  fsm_t              state, state_next;
  phase_t            phase, phase_next;
  logic              frame_done, frame_done_next;
  logic [AW-1:0]     wp, wp_next;
  logic [CNT_W-1:0]  produced, produced_next;
  logic [LEN_W-1:0]  plen, plen_next;
  logic [DH_W-1:0]   dh, dh_next;
  logic [DIST_W-1:0] ref_dist, ref_dist_next;
  logic [LEN_W-1:0]  cnt, cnt_next;
  logic              run_mem, run_mem_next;
  logic [7:0]        run_byte, run_byte_next;
  logic              run_end, run_end_next;
  logic              fmt;
  logic [7:0]        fin_byte;

  logic [7:0]        b;
  logic              e;
  logic              acc;
  logic [AW-1:0]     wp_inc;
  logic [CNT_W-1:0]  prod_inc;
  logic              cap_hit;
  logic [DIST_W-1:0] dist_calc;
  logic              dist_err;
  logic [AW:0]       diff;
  logic [AW:0]       diff_wrap;
  logic [LEN_W-1:0]  pl_dec;
  logic              lit_done;
  logic              lit_fin;
  logic              run_fin;

  assign b   = in_ch.packed_byte;
  assign e   = in_ch.stream_end;
  assign in_ch.ready = (state == S_IDLE) && iss_ready;
  assign acc = in_ch.valid && in_ch.ready;

  assign wp_inc   = (wp == AW'(WINDOW_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign prod_inc = (produced == '1) ? produced : produced + 1'b1;
  assign cap_hit  = (32'(prod_inc) >= 32'(MAX_OUTPUT));

  assign dist_calc = DIST_W'(dh) + DIST_W'(b) + DIST_W'(2);
  assign dist_err  = (CNT_W'(dist_calc) > produced) || (32'(dist_calc) > 32'(WINDOW_DEPTH));

  // source address wraps around the window; distance is at least two, so the
  // byte being read has already been written back
  assign diff      = (AW+1)'(wp) - (AW+1)'(ref_dist);
  assign diff_wrap = diff + (AW+1)'(WINDOW_DEPTH);
  assign rd_addr   = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];

  assign pl_dec   = (plen != '0) ? plen - 1'b1 : '0;
  assign lit_done = (pl_dec == '0);
  assign lit_fin  = e || cap_hit;
  assign run_fin  = run_end || cap_hit;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc && !frame_done) begin
          priority if (phase == PH_DIST && !dist_err) begin
            state_next = S_RUN;
          end else if (phase == PH_FILL) begin
            state_next = S_RUN;
          end else if (phase == PH_LIT && lit_done && lit_fin) begin
            state_next = S_FINAL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_RUN: begin
        if (iss_ready && cnt == LEN_W'(1)) begin
          state_next = run_fin ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        if (iss_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and frame state updates
  always_comb begin
    phase_next      = phase;
    frame_done_next = frame_done;
    wp_next         = wp;
    produced_next   = produced;
    plen_next       = plen;
    dh_next         = dh;
    ref_dist_next   = ref_dist;
    cnt_next        = cnt;
    run_mem_next    = run_mem;
    run_byte_next   = run_byte;
    run_end_next    = run_end;
    iss_valid       = 1'b0;
    iss             = '0;
    iss_byte        = '0;
    iss_waddr       = wp;
    rd_en           = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (acc) begin
          if (frame_done) begin
            if (e) begin
              wp_next = '0; produced_next = '0; phase_next = PH_TOKEN;
              plen_next = '0; dh_next = '0; frame_done_next = 1'b0;
            end
          end else begin
            unique case (phase)
              PH_DIST: begin
                phase_next = PH_TOKEN;
                if (dist_err) begin
                  iss_valid  = 1'b1;
                  iss.last   = 1'b1;
                  iss.status = FS_ERR;
                  frame_done_next = 1'b1;
                end else begin
                  ref_dist_next = dist_calc;
                  cnt_next      = plen;
                  run_mem_next  = 1'b1;
                  run_end_next  = e;
                end
              end
              PH_FILL: begin
                phase_next    = PH_TOKEN;
                cnt_next      = plen;
                run_mem_next  = 1'b0;
                run_byte_next = b;
                run_end_next  = e;
              end
              PH_LIT: begin
                iss_valid    = 1'b1;
                iss.has_byte = 1'b1;
                iss.write    = 1'b1;
                iss_byte     = b;
                wp_next       = wp_inc;
                produced_next = prod_inc;
                plen_next     = pl_dec;
                if (lit_done) begin
                  phase_next   = PH_TOKEN;
                  run_end_next = e;
                  iss.last     = !lit_fin;
                end else if (e) begin
                  // stream cut inside the literal run
                  iss.has_byte = 1'b0;
                  iss.write    = 1'b0;
                  iss.last     = 1'b1;
                  iss.status   = FS_ERR;
                end else begin
                  iss.last = 1'b1;
                end
              end
              PH_TOKEN: begin
                phase_next = PH_TOKEN;
                if (b == 8'd0) begin
                  iss_valid    = 1'b1;
                  iss.has_byte = 1'b1;
                  iss.last     = 1'b1;
                  iss.status   = FS_OK;
                  iss_byte     = fin_byte;
                  frame_done_next = 1'b1;
                end else begin
                  priority if (b[7]) begin
                    if (fmt) begin
                      plen_next = LEN_W'(b[7:4]) - REF_BIAS1;
                      dh_next   = {b[3:0], 8'h00};
                    end else begin
                      plen_next = LEN_W'(b[3:0]) + REF_BIAS0;
                      dh_next   = {1'b0, b[6:4], 8'h00};
                    end
                    phase_next = PH_DIST;
                  end else if (b[6]) begin
                    plen_next  = b[6:0] - FILL_BIAS;
                    phase_next = PH_FILL;
                  end else begin
                    plen_next  = LEN_W'(b[5:0]);
                    phase_next = PH_LIT;
                  end
                  if (e) begin
                    iss_valid  = 1'b1;
                    iss.last   = 1'b1;
                    iss.status = FS_ERR;
                  end
                end
              end
            endcase
            // a finish on a byte with stream_end starts a new frame at once
            if (e && (iss.status != FS_ONGOING)) begin
              wp_next = '0; produced_next = '0; phase_next = PH_TOKEN;
              plen_next = '0; dh_next = '0; frame_done_next = 1'b0;
            end
          end
        end
      end
      S_RUN: begin
        iss_valid    = 1'b1;
        iss.has_byte = 1'b1;
        iss.write    = 1'b1;
        iss.from_mem = run_mem;
        iss.last     = (cnt == LEN_W'(1)) && !run_fin;
        iss_byte     = run_byte;
        rd_en        = run_mem && iss_ready;
        if (iss_ready) begin
          wp_next       = wp_inc;
          produced_next = prod_inc;
          cnt_next      = cnt - 1'b1;
        end
      end
      S_FINAL: begin
        iss_valid    = 1'b1;
        iss.has_byte = 1'b1;
        iss.last     = 1'b1;
        iss.status   = FS_OK;
        iss_byte     = fin_byte;
        if (iss_ready) begin
          if (run_end) begin
            wp_next = '0; produced_next = '0; phase_next = PH_TOKEN;
            plen_next = '0; dh_next = '0; frame_done_next = 1'b0;
          end else begin
            frame_done_next = 1'b1;
          end
        end
      end
      default: begin
        iss_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_TOKEN;
      frame_done <= 1'b0;
      wp         <= '0;
      produced   <= '0;
      plen       <= '0;
      dh         <= '0;
      cnt        <= '0;
      fmt        <= 1'b0;
      fin_byte   <= '0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      frame_done <= frame_done_next;
      wp         <= wp_next;
      produced   <= produced_next;
      plen       <= plen_next;
      dh         <= dh_next;
      cnt        <= cnt_next;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_FORMAT: fmt      <= cfg_wdata[0];
          REG_FINAL:  fin_byte <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ref_dist <= ref_dist_next;
    run_mem  <= run_mem_next;
    run_byte <= run_byte_next;
    run_end  <= run_end_next;
  end

endmodule

// File: rtl/lzb_pack.sv
// ----------------------------------------------------------------------------
// lzb_pack
// Write-back stage and output packer: takes one byte event per cycle while the
// output is free; writes history; pairs bytes into the registered result.
// ----------------------------------------------------------------------------
module lzb_pack #(
  parameter int unsigned WINDOW_DEPTH = lzb_pkg::WINDOW_DEPTH_DEF,
  localparam int unsigned AW = $clog2(WINDOW_DEPTH)
) (
  input  logic           clk,
  input  logic           rst,
  input  lzb_pkg::iss_t  iss,
  input  logic           iss_valid,
  output logic           iss_ready,
  input  logic [7:0]     iss_byte,
  input  logic [AW-1:0]  iss_waddr,
  input  logic [7:0]     rd_data,
  output logic           wr_en,
  output logic [AW-1:0]  wr_addr,
  output logic [7:0]     wr_data,
  lzb_out_if.source      out_ch
);

  import lzb_pkg::*;

  logic          bv;
  iss_t          bctl;
  logic [7:0]    bimm;
  logic [AW-1:0] baddr;
  logic          half_v;
  logic [7:0]    half_b;

  logic          ovalid;
  logic [7:0]    o_first;
  logic [7:0]    o_second;
  logic [1:0]    o_count;
  logic          o_last;
  status_t       o_status;

  logic [7:0]    bbyte;
  logic          completes;
  logic          out_free;
  logic          b_done;

  assign bbyte     = bctl.from_mem ? rd_data : bimm;
  assign completes = bctl.last || half_v;
  assign out_free  = !ovalid || out_ch.ready;
  assign b_done    = bv && (!completes || out_free);
  assign iss_ready = !bv || b_done;

  assign wr_en   = b_done && bctl.write;
  assign wr_addr = baddr;
  assign wr_data = bbyte;

  assign out_ch.valid        = ovalid;
  assign out_ch.first_byte   = o_first;
  assign out_ch.second_byte  = o_second;
  assign out_ch.byte_count   = o_count;
  assign out_ch.run_last     = o_last;
  assign out_ch.frame_status = o_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      bv     <= 1'b0;
      half_v <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (iss_ready) begin
        bv <= iss_valid;
      end
      if (b_done && completes) begin
        half_v <= 1'b0;
      end else if (b_done && bctl.has_byte) begin
        half_v <= 1'b1;
      end
      if (b_done && completes) begin
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iss_valid && iss_ready) begin
      bctl  <= iss;
      bimm  <= iss_byte;
      baddr <= iss_waddr;
    end
    if (b_done && !completes) begin
      half_b <= bbyte;
    end
    if (b_done && completes) begin
      o_last   <= bctl.last;
      o_status <= bctl.last ? bctl.status : FS_ONGOING;
      priority if (!bctl.has_byte) begin
        o_first  <= '0;
        o_second <= '0;
        o_count  <= 2'd0;
      end else if (half_v) begin
        o_first  <= half_b;
        o_second <= bbyte;
        o_count  <= 2'd2;
      end else begin
        o_first  <= bbyte;
        o_second <= '0;
        o_count  <= 2'd1;
      end
    end
  end

endmodule

// File: rtl/lz_byte_token_decompressor.sv
// ----------------------------------------------------------------------------
// lz_byte_token_decompressor
// Token and argument bytes are taken while idle; a result passes the packing
// buffer and the output register. A copy or fill runs through the history
// read/write loop (one byte per cycle unless stalled), input held off.
// Sync active-high reset clears frame state and config; history is not cleared.
// ----------------------------------------------------------------------------
module lz_byte_token_decompressor #(
  parameter int unsigned MAX_OUTPUT   = lzb_pkg::MAX_OUTPUT_DEF,
  parameter int unsigned WINDOW_DEPTH = lzb_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lzb_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lzb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  lzb_in_if.sink                          in_ch,
  lzb_out_if.source                       out_ch
);

  import lzb_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  iss_t          iss;
  logic          iss_valid;
  logic          iss_ready;
  logic [7:0]    iss_byte;
  logic [AW-1:0] iss_waddr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  lzb_seq #(
    .MAX_OUTPUT   (MAX_OUTPUT),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .iss       (iss),
    .iss_valid (iss_valid),
    .iss_ready (iss_ready),
    .iss_byte  (iss_byte),
    .iss_waddr (iss_waddr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  lzb_hist_ram #(
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lzb_pack #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_pack (
    .clk       (clk),
    .rst       (rst),
    .iss       (iss),
    .iss_valid (iss_valid),
    .iss_ready (iss_ready),
    .iss_byte  (iss_byte),
    .iss_waddr (iss_waddr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_ch    (out_ch)
  );

endmodule
